// ===== src/lsd_pkg.sv =====
// Shared constants and types for the line segment densifier.
package lsd_pkg;

  localparam int unsigned CoordW = 31;
  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned LenW = 32;
  localparam int unsigned RadW = 2 * DiffW;
  localparam int unsigned SpacingW = 32;
  localparam int unsigned SpacingReset = 65536;
  localparam int unsigned MaxPointsDefault = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the segment and the start point
    logic abs;        // take the absolute differences
    logic square;     // form the sum of squares and clear the root
    logic sqrt_step;  // one digit pair of the square root
    logic cnt_start;  // start the count division
    logic cnt_step;   // one quotient bit of the count division
    logic cnt_fix;    // round up and clamp the count, start the step divisions
    logic stp_step;   // one quotient bit of both step divisions
    logic stp_fix;    // apply signs to the steps
    logic advance;    // move to the next point
  } lsd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_zero;
    logic last_pt;
    logic next_last;
  } lsd_sts_t;

endpackage

// ===== src/lsd_datapath.sv =====
// Datapath: square root, count and step division units, and point accumulators.
module lsd_datapath #(
  parameter int unsigned MAX_POINTS = lsd_pkg::MaxPointsDefault
) (
  input  logic                              clk,
  input  lsd_pkg::lsd_cmd_t                 cmd,
  input  logic [lsd_pkg::SpacingW-1:0]      spacing,
  input  logic signed [lsd_pkg::CoordW-1:0] start_x,
  input  logic signed [lsd_pkg::CoordW-1:0] start_y,
  input  logic signed [lsd_pkg::CoordW-1:0] end_x,
  input  logic signed [lsd_pkg::CoordW-1:0] end_y,
  output lsd_pkg::lsd_sts_t                 sts,
  output logic signed [lsd_pkg::CoordW-1:0] px,
  output logic signed [lsd_pkg::CoordW-1:0] py,
  output logic                              sat
);
  import lsd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned RemW = LenW + 2;
  localparam int unsigned FullW = LenW + 1;

  logic signed [DiffW-1:0] dx, dy;
  logic [DiffW-1:0] adx, ady;
  logic [2*DiffW-1:0] sqx, sqy;
  logic [RadW-1:0] rad;
  logic [RemW-1:0] rem, rem_sh, trial;
  logic [LenW-1:0] root;
  logic [LenW-1:0] cq;
  logic [SpacingW:0] cr, cr_sh;
  logic [FullW-1:0] cnt_full;
  logic [CntW-1:0] cnt, idx;
  logic [DiffW-1:0] ax, ay;
  logic [CntW:0] rx, ry, rx_sh, ry_sh;
  logic signed [DiffW-1:0] stx, sty;
  logic [SpacingW-1:0] sp;

  assign sp = (spacing == '0) ? SpacingW'(1) : spacing;

  assign sqx = adx * adx;
  assign sqy = ady * ady;

  // Restoring square root, one result bit per digit pair from the top.
  assign rem_sh = {rem[RemW-3:0], rad[RadW-1:RadW-2]};
  assign trial = {root, 2'b01};

  assign cr_sh = {cr[SpacingW-1:0], cq[LenW-1]};
  assign cnt_full = {1'b0, cq} + FullW'(cr != '0);
  assign rx_sh = {rx[CntW-1:0], ax[DiffW-1]};
  assign ry_sh = {ry[CntW-1:0], ay[DiffW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx <= {end_x[CoordW-1], end_x} - {start_x[CoordW-1], start_x};
      dy <= {end_y[CoordW-1], end_y} - {start_y[CoordW-1], start_y};
      px <= start_x;
      py <= start_y;
      sat <= 1'b0;
    end else if (cmd.abs) begin
      adx <= dx[DiffW-1] ? -dx : dx;
      ady <= dy[DiffW-1] ? -dy : dy;
    end else if (cmd.square) begin
      rad <= sqx + sqy;
      rem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        root <= {root[LenW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        root <= {root[LenW-2:0], 1'b0};
      end
    end else if (cmd.cnt_start) begin
      cq <= root;
      cr <= '0;
    end else if (cmd.cnt_step) begin
      if (cr_sh >= {1'b0, sp}) begin
        cr <= cr_sh - {1'b0, sp};
        cq <= {cq[LenW-2:0], 1'b1};
      end else begin
        cr <= cr_sh;
        cq <= {cq[LenW-2:0], 1'b0};
      end
    end else if (cmd.cnt_fix) begin
      if (cnt_full > FullW'(MAX_POINTS)) begin
        cnt <= CntW'(MAX_POINTS);
        sat <= 1'b1;
      end else begin
        cnt <= cnt_full[CntW-1:0];
        sat <= 1'b0;
      end
      ax <= adx;
      ay <= ady;
      rx <= '0;
      ry <= '0;
      idx <= '0;
    end else if (cmd.stp_step) begin
      // Both step divisions of |d| by the count run side by side.
      if (rx_sh >= {1'b0, cnt}) begin
        rx <= rx_sh - {1'b0, cnt};
        ax <= {ax[DiffW-2:0], 1'b1};
      end else begin
        rx <= rx_sh;
        ax <= {ax[DiffW-2:0], 1'b0};
      end
      if (ry_sh >= {1'b0, cnt}) begin
        ry <= ry_sh - {1'b0, cnt};
        ay <= {ay[DiffW-2:0], 1'b1};
      end else begin
        ry <= ry_sh;
        ay <= {ay[DiffW-2:0], 1'b0};
      end
    end else if (cmd.stp_fix) begin
      stx <= dx[DiffW-1] ? -$signed(ax) : $signed(ax);
      sty <= dy[DiffW-1] ? -$signed(ay) : $signed(ay);
    end else if (cmd.advance) begin
      px <= px + stx[CoordW-1:0];
      py <= py + sty[CoordW-1:0];
      idx <= idx + CntW'(1);
    end
  end

  always_comb begin
    sts.len_zero = (root == '0);
    sts.last_pt = (idx == cnt - CntW'(1));
    sts.next_last = (idx + CntW'(1) == cnt - CntW'(1));
  end
endmodule

// ===== src/lsd_ctrl.sv =====
// Controller state machine that sequences the datapath and the handshakes.
module lsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              last,
  input  lsd_pkg::lsd_sts_t sts,
  output lsd_pkg::lsd_cmd_t cmd
);
  import lsd_pkg::*;

  localparam int unsigned CW = $clog2(LenW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ABS, S_SQ, S_SQRT, S_LEN, S_CNT, S_CFIX, S_STEP, S_SFIX, S_EMIT
  } state_t;

  state_t state;
  logic [CW-1:0] step;

  always_comb begin
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.abs = (state == S_ABS);
    cmd.square = (state == S_SQ);
    cmd.sqrt_step = (state == S_SQRT);
    cmd.cnt_start = (state == S_LEN);
    cmd.cnt_step = (state == S_CNT);
    cmd.cnt_fix = (state == S_CFIX);
    cmd.stp_step = (state == S_STEP);
    cmd.stp_fix = (state == S_SFIX);
    cmd.advance = (state == S_EMIT) && out_ready && !last;
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      out_valid <= 1'b0;
      last <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_ABS;
        end
        S_ABS: begin
          state <= S_SQ;
          step <= '0;
        end
        S_SQ: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (step == CW'(LenW - 1)) begin
            step <= '0;
            state <= S_LEN;
          end else begin
            step <= step + CW'(1);
          end
        end
        S_LEN: begin
          if (sts.len_zero) begin
            state <= S_EMIT;
            out_valid <= 1'b1;
            last <= 1'b1;
          end else begin
            state <= S_CNT;
          end
        end
        S_CNT: begin
          if (step == CW'(LenW - 1)) begin
            step <= '0;
            state <= S_CFIX;
          end else begin
            step <= step + CW'(1);
          end
        end
        S_CFIX: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (step == CW'(DiffW - 1)) begin
            step <= '0;
            state <= S_SFIX;
          end else begin
            step <= step + CW'(1);
          end
        end
        S_SFIX: begin
          state <= S_EMIT;
          out_valid <= 1'b1;
          last <= sts.last_pt;
        end
        S_EMIT: begin
          if (out_ready) begin
            if (last) begin
              out_valid <= 1'b0;
              last <= 1'b0;
              state <= S_IDLE;
            end else begin
              last <= sts.next_last;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/line_segment_densifier_unit.sv =====
// Top level of the line segment densifier.
// An input item carries one segment (start and end points, signed Q15.16)
// and is accepted when in_valid and in_ready are both high. in_ready is high
// only while the block is idle, so one segment is worked at a time.
// Each segment yields 1 to MAX_POINTS result items (point_x, point_y, last,
// saturated), taken when out_valid and out_ready are both high; last marks
// the final item of the segment.
// After acceptance, the block forms the absolute differences and the sum
// of squares, runs the bit-serial square root, checks the length, divides
// by spacing, rounds and clamps the count, divides for the steps and signs
// them; the first item then becomes valid. A zero-length segment goes from
// the length check straight to its single item. Further points follow one
// per cycle while out_ready stays high. The serial square root and the
// dividers take up most of the time that a segment occupies the block.
// When the receiver stalls, the current item holds on the outputs.
// Reset (rst, synchronous) returns to idle, drops out_valid and sets
// spacing to 1.0. spacing may be written only while idle.
module line_segment_densifier_unit #(
  parameter int unsigned MAX_POINTS = lsd_pkg::MaxPointsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lsd_pkg::SpacingW-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [lsd_pkg::CoordW-1:0] start_x,
  input  logic signed [lsd_pkg::CoordW-1:0] start_y,
  input  logic signed [lsd_pkg::CoordW-1:0] end_x,
  input  logic signed [lsd_pkg::CoordW-1:0] end_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lsd_pkg::CoordW-1:0] point_x,
  output logic signed [lsd_pkg::CoordW-1:0] point_y,
  output logic                              last,
  output logic                              saturated
);
  import lsd_pkg::*;

  logic [SpacingW-1:0] spacing;
  lsd_cmd_t cmd;
  lsd_sts_t sts;
  logic sat;

  always_ff @(posedge clk) begin
    if (rst) spacing <= SpacingW'(SpacingReset);
    else if (cfg_we) spacing <= cfg_wdata;
  end

  lsd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .last,
    .sts, .cmd
  );

  lsd_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .cmd, .spacing, .start_x, .start_y, .end_x, .end_y, .sts,
    .px(point_x), .py(point_y), .sat
  );

  assign saturated = sat & ~sts.len_zero;
endmodule

// ===== src/lsd_checker.sv =====
// Port-level checker for the line segment densifier, bound to the top level.
module lsd_port_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic last
);
  // No new segment is taken while results are still pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during output");
  // Accepting a segment never shows a result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // The final item of a segment returns the block to idle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready) else $error("no idle after last");
  // A stalled result holds its last flag.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(last)) else $error("item dropped");
endmodule

bind line_segment_densifier_unit lsd_port_checker u_lsd_port_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .last
);
